// ===== rtl/philox_counter_rng_assert.svh =====
// Assertion macros for the checker file of the Philox generator.
// Each use expands to one labeled concurrent assertion on clock and reset.
`ifndef PHILOX_COUNTER_RNG_ASSERT_SVH
`define PHILOX_COUNTER_RNG_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define PCR_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pcr_pkg.sv =====
// Types and constants for the Philox4x32 counter-based generator.
// No dependencies; used by every RTL module of the block.
package pcr_pkg;

   localparam logic [31:0] MUL_A  = 32'hD2511F53;
   localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
   localparam logic [31:0] WEYL_A = 32'h9E3779B9;
   localparam logic [31:0] WEYL_B = 32'hBB67AE85;

   // Counter blocks per generate item, and 64-bit words they yield
   localparam int BLOCKS    = 4;
   localparam int WORDS_MAX = 2 * BLOCKS;
   localparam int CNT_W     = $clog2(WORDS_MAX + 1);

   localparam logic OP_GENERATE = 1'b0;
   localparam logic OP_SKIP     = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW            = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH           = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COUNTER_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COUNTER_HIGH = 3'd3;

   typedef struct packed {
      logic        op;
      logic [63:0] amount;
   } pcr_req_type;

   typedef struct packed {
      logic [63:0] random_word;
      logic        last;
   } pcr_rsp_type;

   // Per-cycle command to every cell of the chain
   typedef struct packed {
      logic load;
      logic round;
      logic shift;
   } pcr_cell_ctl_type;

endpackage

// ===== rtl/pcr_cell.sv =====
// One Philox4x32 cell: holds the four 32-bit words of one counter block.
// Loads a counter, runs one round per cycle, then shifts words to its neighbor.
// Depends on pcr_pkg.
module pcr_cell import pcr_pkg::*; (
   input  logic             clock,
   input  pcr_cell_ctl_type ctl,
   input  logic [31:0]      key_a,
   input  logic [31:0]      key_b,
   input  logic [63:0]      load_lo,
   input  logic [63:0]      load_hi,
   input  logic [63:0]      shift_word,
   output logic [63:0]      head_word
);

   logic [31:0] x0_ff, x1_ff, x2_ff, x3_ff;
   logic [31:0] x0_in, x1_in, x2_in, x3_in;
   logic [63:0] pa, pb;

   // 32x32 products, operands zero-extended to the 64-bit result
   assign pa = 64'(MUL_A) * 64'(x0_ff);
   assign pb = 64'(MUL_B) * 64'(x2_ff);

   always_comb begin
      x0_in = x0_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      x3_in = x3_ff;
      if (ctl.load) begin
         x0_in = load_lo[31:0];
         x1_in = load_lo[63:32];
         x2_in = load_hi[31:0];
         x3_in = load_hi[63:32];
      end else if (ctl.round) begin
         x0_in = pb[63:32] ^ x1_ff ^ key_a;
         x1_in = pb[31:0];
         x2_in = pa[63:32] ^ x3_ff ^ key_b;
         x3_in = pa[31:0];
      end else if (ctl.shift) begin
         // upper word moves down, neighbor's lower word moves in
         x0_in = x2_ff;
         x1_in = x3_ff;
         x2_in = shift_word[31:0];
         x3_in = shift_word[63:32];
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      x3_ff <= x3_in;
   end

   assign head_word = {x1_ff, x0_ff};

endmodule

// ===== rtl/philox_counter_rng.sv =====
// Philox4x32 generator. A generate item loads the counter blocks into the
// cells, then runs ROUNDS rounds (each cell runs one round a cycle on its two
// 32x32 multipliers), then emits one word per cycle while rsp_ready is high,
// up to WORDS_MAX words. A skip item adds its amount to the low counter half;
// when that add carries, the carry lands in the high half in the next cycle
// and no new item is taken until it has. A generate of zero words is ignored.
// The user writes key and counter through the csr port only while idle; the
// block itself does not enforce it. Writing a start counter half loads the
// live counter at once.
module philox_counter_rng import pcr_pkg::*; #(
   parameter int ROUNDS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pcr_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pcr_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   localparam int RND_W = $clog2(ROUNDS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [31:0]       key_lo_ff, key_hi_ff;
   logic [31:0]       ka_ff, kb_ff;
   logic [63:0]       ctr_lo_ff, ctr_hi_ff;
   logic              carry_ff;
   logic [RND_W-1:0]  rnd_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic              req_fire;
   logic [63:0]       addend;
   logic [64:0]       ctr_sum;
   logic [63:0]       ctr_hi_inc;
   logic [CNT_W-1:0]  n_sat;
   pcr_cell_ctl_type  cell_ctl;
   logic [63:0]       chain_word [BLOCKS:0];

   assign req_ready  = (state_ff == ST_IDLE) && !carry_ff;
   assign req_fire   = req_valid && req_ready;
   assign addend     = (state_ff == ST_LOAD) ? 64'(BLOCKS) : req_data.amount;
   assign ctr_sum    = {1'b0, ctr_lo_ff} + {1'b0, addend};
   assign ctr_hi_inc = ctr_hi_ff + 64'd1;
   assign n_sat      = (req_data.amount > 64'(WORDS_MAX)) ? CNT_W'(WORDS_MAX)
                                                          : req_data.amount[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         key_lo_ff <= '0;
         key_hi_ff <= '0;
         ctr_lo_ff <= '0;
         ctr_hi_ff <= '0;
         carry_ff  <= 1'b0;
         rnd_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         // registered carry from the low-half add increments the high half
         if (carry_ff) begin
            ctr_hi_ff <= ctr_hi_inc;
            carry_ff  <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_data.op == OP_SKIP) begin
                     ctr_lo_ff <= ctr_sum[63:0];
                     carry_ff  <= ctr_sum[64];
                  end else if (req_data.amount != 64'd0) begin
                     cnt_ff   <= n_sat;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               // cells take the old counter at this edge; counter advances
               ka_ff     <= key_lo_ff;
               kb_ff     <= key_hi_ff;
               rnd_ff    <= '0;
               ctr_lo_ff <= ctr_sum[63:0];
               carry_ff  <= ctr_sum[64];
               state_ff  <= ST_ROUND;
            end
            ST_ROUND: begin
               ka_ff  <= ka_ff + WEYL_A;
               kb_ff  <= kb_ff + WEYL_B;
               rnd_ff <= rnd_ff + 1'b1;
               if (rnd_ff == RND_W'(ROUNDS - 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_LOW:            key_lo_ff <= csr_wdata[31:0];
               CSR_KEY_HIGH:           key_hi_ff <= csr_wdata[31:0];
               CSR_START_COUNTER_LOW:  ctr_lo_ff <= csr_wdata;
               CSR_START_COUNTER_HIGH: ctr_hi_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   assign cell_ctl.load  = (state_ff == ST_LOAD);
   assign cell_ctl.round = (state_ff == ST_ROUND);
   assign cell_ctl.shift = (state_ff == ST_EMIT) && rsp_ready;

   assign chain_word[BLOCKS] = '0;

   for (genvar b = 0; b < BLOCKS; b++) begin : g_cell
      logic [64:0] blk_lo;
      logic [63:0] blk_hi;

      assign blk_lo = {1'b0, ctr_lo_ff} + 65'(b);
      assign blk_hi = blk_lo[64] ? ctr_hi_inc : ctr_hi_ff;

      pcr_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .key_a      (ka_ff),
         .key_b      (kb_ff),
         .load_lo    (blk_lo[63:0]),
         .load_hi    (blk_hi),
         .shift_word (chain_word[b+1]),
         .head_word  (chain_word[b])
      );
   end

   assign rsp_valid            = (state_ff == ST_EMIT);
   assign rsp_data.random_word = chain_word[0];
   assign rsp_data.last        = (cnt_ff == CNT_W'(1));

endmodule

// ===== rtl/pcr_checker.sv =====
// Port-level checks for philox_counter_rng, bound to the top level.
// Depends on pcr_pkg and philox_counter_rng_assert.svh.
`include "philox_counter_rng_assert.svh"

module pcr_checker import pcr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input pcr_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input pcr_rsp_type rsp_data
);

   // one item in flight: never taking a new item while words are pending
   `PCR_ASSERT_NOW(a_one_item, !(req_ready && rsp_valid), "item taken while words pending")

   `PCR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled word changed")

   `PCR_ASSERT_NEXT(a_skip_silent, req_valid && req_ready && req_data.op == OP_SKIP, !rsp_valid, "skip item gave a word")

   `PCR_ASSERT_NEXT(a_empty_gen, req_valid && req_ready && req_data.op == OP_GENERATE && req_data.amount == 64'd0, req_ready && !rsp_valid, "empty generate not ignored")

   `PCR_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_data.last, !rsp_valid, "word after last")

endmodule

bind philox_counter_rng pcr_checker u_pcr_checker (.*);
